### rtl/ffca_pkg.sv
// Package for the first-fit channel allocator.
// Input/result word structs and the control word carried along the cell chain.
// No dependencies.
package ffca_pkg;

  localparam int ARRIVAL_W = 1;
  localparam int IN_HOLD_W = 16;
  localparam int CFG_W     = 7;
  localparam int GRANT_W   = 6;
  localparam int BUSY_W    = 7;
  localparam int TOTAL_W   = 32;

  typedef struct packed {
    logic                 arrival;
    logic [IN_HOLD_W-1:0] hold_ticks;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic               dropped;
    logic [GRANT_W-1:0] granted_channel;
    logic [BUSY_W-1:0]  busy_count;
    logic [TOTAL_W-1:0] drop_total;
    logic [TOTAL_W-1:0] connect_total;
    logic [TOTAL_W-1:0] arrival_total;
  } out_word_t;

  // Control carried by the tick wave as it walks the chain.
  typedef struct packed {
    logic valid;
    logic arrival;
    logic found;
  } wave_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

### rtl/ffca_cell.sv
// One channel cell: busy flag and remaining hold count.
// Processes the tick wave when it passes, then hands it to the next cell.
// Depends on ffca_pkg.
module ffca_cell import ffca_pkg::*; #(
  parameter int IDX        = 0,
  parameter int HOLD_WIDTH = 16,
  parameter int CH_W       = 6,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CFG_W-1:0]      active_i,
  input  logic [HOLD_WIDTH-1:0] hold_i,
  input  wave_t                 wave_i,
  input  logic [CH_W-1:0]       gnt_i,
  input  logic [CNT_W-1:0]      cnt_i,
  output wave_t                 wave_o,
  output logic [CH_W-1:0]       gnt_o,
  output logic [CNT_W-1:0]      cnt_o
);

  logic                  busy_r;
  logic [HOLD_WIDTH-1:0] rem_r;
  logic [HOLD_WIDTH-1:0] rem_dec;
  logic [HOLD_WIDTH-1:0] rem_nxt;
  logic                  cell_active;
  logic                  grab;
  logic                  busy_pre;
  logic                  busy_nxt;
  wave_t                 wave_r;
  logic [CH_W-1:0]       gnt_r;
  logic [CNT_W-1:0]      cnt_r;

  assign cell_active = (32'(active_i) > 32'(IDX));
  assign rem_dec     = (busy_r && rem_r != '0) ? rem_r - HOLD_WIDTH'(1) : rem_r;
  assign grab        = wave_i.arrival && !wave_i.found && !busy_r && cell_active;
  assign busy_pre    = busy_r | grab;
  assign rem_nxt     = grab ? hold_i : rem_dec;
  // expired channels drop out, including one granted this tick with zero hold
  assign busy_nxt    = busy_pre && (rem_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      wave_r.valid <= 1'b0;
    end else begin
      wave_r.valid <= wave_i.valid;
      if (wave_i.valid) begin
        busy_r <= busy_nxt;
      end
    end
    if (wave_i.valid) begin
      rem_r <= rem_nxt;
    end
    wave_r.arrival <= wave_i.arrival;
    wave_r.found   <= wave_i.found | grab;
    gnt_r          <= grab ? CH_W'(IDX) : gnt_i;
    cnt_r          <= cnt_i + CNT_W'(busy_nxt);
  end

  assign wave_o = wave_r;
  assign gnt_o  = gnt_r;
  assign cnt_o  = cnt_r;

endmodule

### rtl/first_fit_channel_allocator_top.sv
// Channel   | Direction | Signals                          | Word
// in        | input     | in_valid, in_ready, in_data      | in_word_t (arrival, hold_ticks)
// out       | output    | out_valid, out_ready, out_data   | out_word_t (grant, counts, totals)
// cfg       | input     | cfg_valid, cfg_ready, cfg_active_channels | active channel count
//
// Each tick word walks the chain of MAX_CHANNELS cells, one cell per cycle; its result is
// registered at the output once the wave leaves the last cell, and one tick is in flight at a time.
// The next tick is taken the cycle after the previous one leaves the chain, even if its
// result still waits at the output (a skid register holds one more; with that full,
// input stalls until the output drains).
// Synchronous active-low reset: all channels free, totals zero, active count 50.
// Depends on ffca_pkg and ffca_cell.
module first_fit_channel_allocator_top import ffca_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int HOLD_WIDTH   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_active_channels
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int HX_W   = (HOLD_WIDTH > IN_HOLD_W) ? HOLD_WIDTH : IN_HOLD_W;
  localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};
  localparam logic [CFG_W-1:0]      ACTIVE_RST = CFG_W'(50);

  logic [CFG_W-1:0]      active_r;
  logic                  running_r;
  logic [HOLD_WIDTH-1:0] hold_r;
  logic [HX_W-1:0]       hold_x;
  logic [HOLD_WIDTH-1:0] hold_sat;
  logic                  in_fire;
  logic                  done;

  wave_t           wave   [MAX_CHANNELS+1];
  logic [CH_W-1:0] gnt    [MAX_CHANNELS+1];
  logic [CNT_W-1:0] cnt   [MAX_CHANNELS+1];
  wave_t           wave0_r;

  logic [TOTAL_W-1:0] drop_tot_r, conn_tot_r, arr_tot_r;
  logic [TOTAL_W-1:0] drop_tot_nxt, conn_tot_nxt, arr_tot_nxt;
  logic               res_acc, res_drp;
  logic [CH_W+GRANT_W-1:0] gnt_ext;
  logic [CNT_W+BUSY_W-1:0] cnt_ext;
  out_word_t          res;
  out_word_t          out_data_r, skid_r;
  logic               out_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !running_r && !skid_valid_r;
  assign in_fire   = in_valid && in_ready;

  assign hold_x   = HX_W'(in_data.hold_ticks);
  assign hold_sat = (hold_x > HX_W'(HOLD_MAX)) ? HOLD_MAX : hold_x[HOLD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= ACTIVE_RST;
      running_r     <= 1'b0;
      wave0_r.valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_r <= cfg_active_channels;
      end
      wave0_r.valid <= in_fire;
      if (in_fire) begin
        running_r <= 1'b1;
      end else if (done) begin
        running_r <= 1'b0;
      end
    end
    if (in_fire) begin
      wave0_r.arrival <= in_data.arrival;
      hold_r          <= hold_sat;
    end
    wave0_r.found <= 1'b0;
  end

  assign wave[0] = wave0_r;
  assign gnt[0]  = '0;
  assign cnt[0]  = '0;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    ffca_cell #(
      .IDX        (i),
      .HOLD_WIDTH (HOLD_WIDTH),
      .CH_W       (CH_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active_i (active_r),
      .hold_i   (hold_r),
      .wave_i   (wave[i]),
      .gnt_i    (gnt[i]),
      .cnt_i    (cnt[i]),
      .wave_o   (wave[i+1]),
      .gnt_o    (gnt[i+1]),
      .cnt_o    (cnt[i+1])
    );
  end

  assign done = wave[MAX_CHANNELS].valid;

  // tick result once the wave leaves the last cell
  assign res_acc      = wave[MAX_CHANNELS].arrival && wave[MAX_CHANNELS].found;
  assign res_drp      = wave[MAX_CHANNELS].arrival && !wave[MAX_CHANNELS].found;
  assign arr_tot_nxt  = wave[MAX_CHANNELS].arrival ? sat_inc(arr_tot_r) : arr_tot_r;
  assign conn_tot_nxt = res_acc ? sat_inc(conn_tot_r) : conn_tot_r;
  assign drop_tot_nxt = res_drp ? sat_inc(drop_tot_r) : drop_tot_r;
  assign gnt_ext      = (CH_W+GRANT_W)'(gnt[MAX_CHANNELS]);
  assign cnt_ext      = (CNT_W+BUSY_W)'(cnt[MAX_CHANNELS]);

  always_comb begin
    res                 = '0;
    res.accepted        = res_acc;
    res.dropped         = res_drp;
    res.granted_channel = res_acc ? gnt_ext[GRANT_W-1:0] : '0;
    res.busy_count      = cnt_ext[BUSY_W-1:0];
    res.drop_total      = drop_tot_nxt;
    res.connect_total   = conn_tot_nxt;
    res.arrival_total   = arr_tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_tot_r   <= '0;
      conn_tot_r   <= '0;
      arr_tot_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (done) begin
        drop_tot_r <= drop_tot_nxt;
        conn_tot_r <= conn_tot_nxt;
        arr_tot_r  <= arr_tot_nxt;
        if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_data_r  <= res;
        end else begin
          skid_valid_r <= 1'b1;
          skid_r       <= res;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r  <= skid_valid_r;
        out_data_r   <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/ffca_checker.sv
// Port-level checks for the first-fit channel allocator, bound to the top level.
// Depends on ffca_pkg and first_fit_channel_allocator_top.
module ffca_checker import ffca_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // one tick in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_acc_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && out_data.dropped))
    else $error("word both accepted and dropped");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.granted_channel == '0)
    else $error("nonzero channel without a grant");

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.accepted || out_data.dropped) |->
      out_data.arrival_total != '0 &&
      (out_data.dropped ? out_data.drop_total != '0 : out_data.connect_total != '0))
    else $error("total not advanced for this arrival");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind first_fit_channel_allocator_top ffca_checker u_ffca_checker (.*);

### bench/tb.sv
// Testbench for first_fit_channel_allocator_top: directed and random tick words with
// random gaps and output stalls, checked against a local predictor of the channel pool.
// Depends on ffca_pkg and the allocator RTL.
module tb;
  import ffca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS    = 64;
  localparam int HOLD_BITS   = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 125;
  localparam int CYCLE_LIMIT = 1_500_000;

  class alloc_scoreboard;
    bit                 occupied [CHANNELS];
    logic [15:0]        ticks_left [CHANNELS];
    logic [TOTAL_W-1:0] drops, connects, arrivals;
    logic [CFG_W-1:0]   active;
    out_word_t          pending_q [$];
    int                 errors, ticks, grants, blocks, settings;

    function new();
      active = 7'd50;
      drops = '0;
      connects = '0;
      arrivals = '0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (ticks_left[i]) ticks_left[i] = '0;
    endfunction

    function void set_active(logic [CFG_W-1:0] v);
      active = v;
      settings++;
    endfunction

    // One tick: count down, first-fit grant, then release expired channels.
    function void note_tick(in_word_t w);
      out_word_t exp;
      int        lim, cnt;
      bit        found;
      lim = (active > CHANNELS) ? CHANNELS : active;
      cnt = 0;
      found = 1'b0;
      exp = '0;
      ticks++;
      foreach (occupied[i])
        if (occupied[i] && ticks_left[i] != 0) ticks_left[i] = ticks_left[i] - 16'd1;
      if (w.arrival) begin
        arrivals = (arrivals == '1) ? arrivals : arrivals + TOTAL_W'(1);
        for (int i = 0; i < lim; i++) begin
          if (!found && !occupied[i]) begin
            occupied[i] = 1'b1;
            ticks_left[i] = w.hold_ticks;
            found = 1'b1;
            exp.granted_channel = i[GRANT_W-1:0];
          end
        end
        if (found) begin
          exp.accepted = 1'b1;
          connects = (connects == '1) ? connects : connects + TOTAL_W'(1);
          grants++;
        end else begin
          exp.dropped = 1'b1;
          drops = (drops == '1) ? drops : drops + TOTAL_W'(1);
          blocks++;
        end
      end
      foreach (occupied[i]) begin
        if (occupied[i] && ticks_left[i] == 0) occupied[i] = 1'b0;
        if (occupied[i]) cnt++;
      end
      exp.busy_count = cnt[BUSY_W-1:0];
      exp.drop_total = drops;
      exp.connect_total = connects;
      exp.arrival_total = arrivals;
      pending_q.push_back(exp);
    endfunction

    task report(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
      $display("mismatch %s: got 0x%0h, want 0x%0h (result %0d)", what, got, want,
               ticks - pending_q.size());
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result word", TOTAL_W'(got.busy_count), '0);
      end else begin
        want = pending_q.pop_front();
        if (got.accepted !== want.accepted)
          report("accepted", TOTAL_W'(got.accepted), TOTAL_W'(want.accepted));
        if (got.dropped !== want.dropped)
          report("dropped", TOTAL_W'(got.dropped), TOTAL_W'(want.dropped));
        if (got.granted_channel !== want.granted_channel)
          report("granted_channel", TOTAL_W'(got.granted_channel),
                 TOTAL_W'(want.granted_channel));
        if (got.busy_count !== want.busy_count)
          report("busy_count", TOTAL_W'(got.busy_count), TOTAL_W'(want.busy_count));
        if (got.drop_total !== want.drop_total)
          report("drop_total", got.drop_total, want.drop_total);
        if (got.connect_total !== want.connect_total)
          report("connect_total", got.connect_total, want.connect_total);
        if (got.arrival_total !== want.arrival_total)
          report("arrival_total", got.arrival_total, want.arrival_total);
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_active_channels = '0;

  alloc_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              ready_left = 0;
  int              cycles = 0;

  first_fit_channel_allocator_top #(
    .MAX_CHANNELS(CHANNELS),
    .HOLD_WIDTH  (HOLD_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_channels(cfg_active_channels)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.set_active(cfg_active_channels);
    if (rst_n && in_valid && in_ready) sb.note_tick(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result-side backpressure: runs of ready, mostly short stalls, a few long ones.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Valid stays up across back-to-back words; dropped only when a gap follows.
  task send_tick(logic arr, logic [IN_HOLD_W-1:0] hold);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{arrival: arr, hold_ticks: hold};
    do @(posedge clk); while (!in_ready);
  endtask

  // one edge first so the word just accepted is already queued
  task write_active(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_active_channels <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t rand_tick(int act);
    in_word_t w;
    int       q;
    w.arrival = ($urandom_range(0, 99) < 70);
    q = $urandom_range(0, 99);
    if (!w.arrival) w.hold_ticks = IN_HOLD_W'($urandom);
    else if (q < 10) w.hold_ticks = '0;
    else if (q < 92) w.hold_ticks = IN_HOLD_W'($urandom_range(0, 3 * act + 6));
    else w.hold_ticks = IN_HOLD_W'($urandom_range(0, 400));
    return w;
  endfunction

  initial begin
    int       plan [PHASES];
    int       act;
    in_word_t w;
    plan = '{64, 2, 127, 1, 0, 12, 40, 0, 0, 64};
    plan[7] = $urandom_range(0, 127);
    plan[8] = $urandom_range(0, 127);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero hold, ignored hold, same-tick release and regrant, max hold.
    send_tick(1'b1, 16'd0);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'd1);
    send_tick(1'b1, 16'd3);
    send_tick(1'b1, 16'd30);
    send_tick(1'b1, 16'd30);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'd0);
    // no searchable channel: every arrival drops
    write_active(7'd0);
    send_tick(1'b1, 16'd5);
    send_tick(1'b1, 16'd0);
    // channel 0 still held, so a one-channel pool blocks
    write_active(7'd1);
    send_tick(1'b1, 16'd5);
    send_tick(1'b0, 16'h5A5A);
    // count above the pool size clamps to the full pool
    write_active(7'd127);
    repeat (4) send_tick(1'b1, 16'd2);

    for (int p = 0; p < PHASES; p++) begin
      write_active(plan[p][CFG_W-1:0]);
      quiet = (p % 3 == 2);
      act = (plan[p] > CHANNELS) ? CHANNELS : plan[p];
      repeat (PHASE_TICKS) begin
        w = rand_tick(act);
        send_tick(w.arrival, w.hold_ticks);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
    if (sb.pending_q.size() != 0) sb.report("results never arrived", sb.pending_q.size(), 0);

    $display("%0d ticks over %0d active-count settings, %0d calls connected, %0d blocked",
             sb.ticks, sb.settings, sb.grants, sb.blocks);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end
endmodule
